// File: design/stt_pkg.sv
// Shared types, constants and helper functions for the source text tokenizer.
// No dependencies; every other file of the block imports this package.
package stt_pkg;

  localparam int PosBits      = 16;
  localparam int KeywordBytes = 8;
  localparam int OutBits      = 16;
  localparam int OutMax       = (2 ** OutBits) - 1;
  localparam int KwIdxBits    = $clog2(KeywordBytes);
  localparam int FifoDepth    = 4;
  localparam int FifoAw       = $clog2(FifoDepth);
  localparam int FifoCntBits  = $clog2(FifoDepth + 1);
  localparam int KwMaxLen     = 7;

  localparam logic [PosBits-1:0] PosMax = '1;

  typedef enum logic [4:0] {
    TK_INT        = 5'd0,
    TK_DECIMAL    = 5'd1,
    TK_IDENT      = 5'd2,
    TK_KW_INT     = 5'd3,
    TK_KW_DECIMAL = 5'd4,
    TK_KW_STRING  = 5'd5,
    TK_KW_IF      = 5'd6,
    TK_KW_ELSE    = 5'd7,
    TK_KW_INCLUDE = 5'd8,
    TK_STRING     = 5'd9,
    TK_PLUS       = 5'd10,
    TK_MINUS      = 5'd11,
    TK_STAR       = 5'd12,
    TK_SLASH      = 5'd13,
    TK_ASSIGN     = 5'd14,
    TK_EQ         = 5'd15,
    TK_BANG       = 5'd16,
    TK_NE         = 5'd17,
    TK_DOT        = 5'd18,
    TK_COMMA      = 5'd19,
    TK_COLON      = 5'd20,
    TK_SEMI       = 5'd21,
    TK_LPAREN     = 5'd22,
    TK_RPAREN     = 5'd23,
    TK_LBRACE     = 5'd24,
    TK_RBRACE     = 5'd25,
    TK_END        = 5'd26,
    TK_OPEN_STR   = 5'd27
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e            kind;
    logic [OutBits-1:0]   start;
    logic [OutBits-1:0]   length;
    logic                 last;
  } tok_t;

  typedef logic [KeywordBytes-1:0][7:0] prefix_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c == "_") || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return ((c >= 8'd8) && (c <= 8'd13)) || (c == " ");
  endfunction

  // Single-character punctuators; hit is low for any other byte.
  function automatic tok_kind_e punct_kind(logic [7:0] c, output logic hit);
    tok_kind_e k;
    hit = 1'b1;
    k   = TK_PLUS;
    case (c)
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_STAR;
      "/":     k = TK_SLASH;
      ".":     k = TK_DOT;
      ",":     k = TK_COMMA;
      ":":     k = TK_COLON;
      ";":     k = TK_SEMI;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      default: hit = 1'b0;
    endcase
    return k;
  endfunction

  // Saturate a position or span to the output field width.
  function automatic logic [OutBits-1:0] clamp_out(logic [PosBits-1:0] v);
    logic [PosBits+OutBits-1:0] w;
    w = (PosBits + OutBits)'(v);
    if (w > (PosBits + OutBits)'(OutMax)) begin
      return '1;
    end
    return w[OutBits-1:0];
  endfunction

  // Exact keyword match; kw holds the keyword right-aligned, first byte highest.
  function automatic logic kw_hit(prefix_t pre, logic [PosBits-1:0] len,
                                  logic [KwMaxLen*8-1:0] kw, int kwlen);
    logic ok;
    ok = (len == PosBits'(kwlen));
    for (int i = 0; i < KeywordBytes; i++) begin
      if (i < kwlen) begin
        if (pre[i] != kw[(kwlen - 1 - i) * 8 +: 8]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  function automatic tok_kind_e ident_kind(prefix_t pre, logic [PosBits-1:0] len);
    if (kw_hit(pre, len, (KwMaxLen*8)'("int"), 3))     return TK_KW_INT;
    if (kw_hit(pre, len, (KwMaxLen*8)'("decimal"), 7)) return TK_KW_DECIMAL;
    if (kw_hit(pre, len, (KwMaxLen*8)'("string"), 6))  return TK_KW_STRING;
    if (kw_hit(pre, len, (KwMaxLen*8)'("if"), 2))      return TK_KW_IF;
    if (kw_hit(pre, len, (KwMaxLen*8)'("else"), 4))    return TK_KW_ELSE;
    if (kw_hit(pre, len, (KwMaxLen*8)'("include"), 7)) return TK_KW_INCLUDE;
    return TK_IDENT;
  endfunction

endpackage

// File: design/stt_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
// Depends on stt_pkg for the token kind type.
interface stt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface stt_tok_if;
  import stt_pkg::*;

  logic               valid;
  logic               ready;
  tok_kind_e          token_kind;
  logic [OutBits-1:0] token_start;
  logic [OutBits-1:0] token_length;
  logic               last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

// File: design/stt_tok_fifo.sv
// Small token queue: takes up to two tokens a cycle, drives the token channel.
// Depends on stt_pkg and stt_tok_if.
module stt_tok_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            wr_num_i,
  input  stt_pkg::tok_t [1:0]   wr_tok_i,
  output logic                  room_o,
  stt_tok_if.source             tok_o
);
  import stt_pkg::*;

  tok_t [FifoDepth-1:0]   mem_q;
  logic [FifoAw-1:0]      rptr_q, rptr_d;
  logic [FifoAw-1:0]      wptr_q, wptr_d;
  logic [FifoCntBits-1:0] cnt_q, cnt_d;
  logic                   pop;
  logic [FifoAw-1:0]      wptr_nx;

  assign pop     = tok_o.valid && tok_o.ready;
  assign room_o  = (cnt_q <= FifoCntBits'(FifoDepth - 2));
  assign wptr_nx = wptr_q + FifoAw'(1);

  assign tok_o.valid        = (cnt_q != '0);
  assign tok_o.token_kind   = mem_q[rptr_q].kind;
  assign tok_o.token_start  = mem_q[rptr_q].start;
  assign tok_o.token_length = mem_q[rptr_q].length;
  assign tok_o.last_of_run  = mem_q[rptr_q].last;

  always_comb begin
    rptr_d = pop ? rptr_q + FifoAw'(1) : rptr_q;
    wptr_d = wptr_q + FifoAw'(wr_num_i);
    cnt_d  = cnt_q + FifoCntBits'(wr_num_i) - FifoCntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q <= '0;
      wptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_num_i != 2'd0) begin
      mem_q[wptr_q] <= wr_tok_i[0];
    end
    if (wr_num_i == 2'd2) begin
      mem_q[wptr_nx] <= wr_tok_i[1];
    end
  end

endmodule

// File: design/source_text_tokenizer_core.sv
// Top level of the source text tokenizer: byte scanner plus token queue.
// Depends on stt_pkg, stt_if and stt_tok_fifo.
//
// Streaming lexer. One source byte is taken per clock cycle while the
// token queue has room; a zero byte ends the source, flushes any pending
// token, emits an end token and restarts offsets at zero. Each byte yields
// zero, one or two tokens (kind, start, length, last_of_run), which go into
// a four-entry token queue; the token port is driven straight from the
// queue head. The byte port is ready whenever the queue holds two or fewer
// tokens, so with the token side taking one token a cycle the block
// sustains one byte per cycle. A byte that breaks off a pending token and
// then yields one of its own puts two tokens in the queue, and the token
// port, at one token a cycle, sets the long-run rate for such input. There
// is no start-up sweep: the byte port is ready straight out of reset.
module source_text_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  stt_char_if.sink   chr_i,
  stt_tok_if.source  tok_o
);
  import stt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_IDENT  = 3'd1,
    M_NUMBER = 3'd2,
    M_STRING = 3'd3,
    M_EQ     = 3'd4,
    M_BANG   = 3'd5
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] start_q, start_d;
  prefix_t            prefix_q, prefix_d;
  logic               dot_q, dot_d;

  logic               room;
  logic               acc;
  logic [7:0]         c;
  logic [PosBits-1:0] span;
  logic [PosBits-1:0] pos_inc;

  // pending token (broken off by this byte) and fresh token (from this byte)
  tok_t               p_tok, f_tok;
  logic               p_v, f_v;
  logic               done;
  logic               pun_hit;
  tok_kind_e          pun_kind;

  tok_t [1:0]         wr_tok;
  logic [1:0]         wr_num;

  assign c       = chr_i.char_code;
  assign acc     = chr_i.valid && room;
  assign chr_i.ready = room;
  assign span    = (pos_q >= start_q) ? pos_q - start_q : '0;
  assign pos_inc = (pos_q < PosMax) ? pos_q + PosBits'(1) : pos_q;

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    prefix_d = prefix_q;
    dot_d    = dot_q;
    p_v      = 1'b0;
    f_v      = 1'b0;
    p_tok    = '{kind: TK_END, start: clamp_out(start_q), length: clamp_out(span),
                 last: 1'b0};
    f_tok    = '{kind: TK_END, start: clamp_out(pos_q), length: '0, last: 1'b0};
    done     = 1'b0;
    pun_kind = punct_kind(c, pun_hit);

    // Finish or extend the pending token.
    case (mode_q)
      M_STRING: begin
        done = 1'b1;
        if (c == "\"") begin
          p_v        = 1'b1;
          p_tok.kind = TK_STRING;
          mode_d     = M_IDLE;
          pos_d      = pos_inc;
        end else if (c == 8'd0) begin
          // open string at end: error token, then the end token
          p_v        = 1'b1;
          p_tok.kind = TK_OPEN_STR;
          f_v        = 1'b1;
          mode_d     = M_IDLE;
          pos_d      = '0;
        end else begin
          pos_d = pos_inc;
        end
      end
      M_EQ, M_BANG: begin
        p_v    = 1'b1;
        mode_d = M_IDLE;
        if (c == "=") begin
          p_tok.kind   = (mode_q == M_EQ) ? TK_EQ : TK_NE;
          p_tok.length = OutBits'(2);
          pos_d        = pos_inc;
          done         = 1'b1;
        end else begin
          p_tok.kind   = (mode_q == M_EQ) ? TK_ASSIGN : TK_BANG;
          p_tok.length = OutBits'(1);
        end
      end
      M_IDENT: begin
        if (is_letter(c)) begin
          if (span < PosBits'(KeywordBytes)) begin
            prefix_d[span[KwIdxBits-1:0]] = c;
          end
          pos_d = pos_inc;
          done  = 1'b1;
        end else begin
          p_v        = 1'b1;
          p_tok.kind = ident_kind(prefix_q, span);
          mode_d     = M_IDLE;
        end
      end
      M_NUMBER: begin
        if (is_numeral(c)) begin
          pos_d = pos_inc;
          done  = 1'b1;
        end else if ((c == ".") && !dot_q) begin
          dot_d = 1'b1;
          pos_d = pos_inc;
          done  = 1'b1;
        end else begin
          p_v        = 1'b1;
          p_tok.kind = dot_q ? TK_DECIMAL : TK_INT;
          mode_d     = M_IDLE;
        end
      end
      default: begin
        mode_d = M_IDLE;
      end
    endcase

    // Handle the byte afresh when no pending token absorbed it.
    if (!done) begin
      if (c == 8'd0) begin
        f_v    = 1'b1;
        mode_d = M_IDLE;
        pos_d  = '0;
      end else begin
        pos_d = pos_inc;
        if (is_numeral(c)) begin
          mode_d  = M_NUMBER;
          start_d = pos_q;
          dot_d   = 1'b0;
        end else if (is_letter(c)) begin
          mode_d      = M_IDENT;
          start_d     = pos_q;
          prefix_d    = '0;
          prefix_d[0] = c;
        end else if (c == "\"") begin
          // content starts after the quote
          mode_d  = M_STRING;
          start_d = pos_inc;
        end else if (c == "=") begin
          mode_d  = M_EQ;
          start_d = pos_q;
        end else if (c == "!") begin
          mode_d  = M_BANG;
          start_d = pos_q;
        end else if (!is_space(c) && pun_hit) begin
          f_v          = 1'b1;
          f_tok.kind   = pun_kind;
          f_tok.length = OutBits'(1);
        end
      end
    end
  end

  // Pack tokens in order and mark the last one of this byte.
  always_comb begin
    wr_num    = {1'b0, p_v} + {1'b0, f_v};
    wr_tok[0] = p_v ? p_tok : f_tok;
    wr_tok[1] = f_tok;
    wr_tok[0].last = (wr_num == 2'd1);
    wr_tok[1].last = 1'b1;
    if (!acc) begin
      wr_num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pos_q    <= '0;
      start_q  <= '0;
      prefix_q <= '0;
      dot_q    <= 1'b0;
    end else if (acc) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      prefix_q <= prefix_d;
      dot_q    <= dot_d;
    end
  end

  stt_tok_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_num_i (wr_num),
    .wr_tok_i (wr_tok),
    .room_o   (room),
    .tok_o    (tok_o)
  );

endmodule

// File: tb/sv/tb_source_text_tokenizer_core.sv
// Testbench for source_text_tokenizer_core: byte stream in, tokens out, both valid/ready.
// Depends on stt_pkg and the channel interfaces in stt_if; predicts tokens locally.
`timescale 1ns / 100ps

module tb_source_text_tokenizer_core;
  import stt_pkg::*;

  // Scanner modes of the local token predictor.
  typedef enum logic [2:0] {
    SC_IDLE,
    SC_IDENT,
    SC_NUMBER,
    SC_STRING,
    SC_EQ,
    SC_BANG
  } scan_e;

  // One byte on its way into the block; typed rows carry a hand-written token.
  typedef struct {
    bit   typed;
    tok_t tok;
  } note_t;

  // One row of the directed table.
  typedef struct {
    logic [7:0]  c;
    bit          typed;
    tok_kind_e   kind;
    logic [15:0] start;
    logic [15:0] len;
  } plan_row_t;

  localparam int    RandomItems = 850;
  localparam string Letters     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";

  logic clk_i = 1'b0;
  logic rst_ni;

  stt_char_if chr_if ();
  stt_tok_if  tok_if ();

  source_text_tokenizer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .chr_i  (chr_if.sink),
    .tok_o  (tok_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Directed walk. Rows with typed = 1 carry a token that is plain from the rules
  // (end of source, operators, identifier, keyword, empty string); the rest are left to
  // the predictor, including every byte that produces two tokens.
  plan_row_t plan [0:22] = '{
    '{8'h00, 1'b1, TK_END,     16'd0, 16'd0},  // end of source right after reset
    '{"+",   1'b1, TK_PLUS,    16'd0, 16'd1},
    '{8'hFF, 1'b0, TK_INT,     16'd0, 16'd0},  // unknown byte, all ones: dropped
    '{"=",   1'b0, TK_INT,     16'd0, 16'd0},
    '{"=",   1'b1, TK_EQ,      16'd2, 16'd2},
    '{"!",   1'b0, TK_INT,     16'd0, 16'd0},
    '{"a",   1'b1, TK_BANG,    16'd4, 16'd1},  // lone bang broken off by a letter
    '{"1",   1'b1, TK_IDENT,   16'd5, 16'd1},  // identifier broken off by a digit
    '{".",   1'b0, TK_INT,     16'd0, 16'd0},
    '{".",   1'b0, TK_INT,     16'd0, 16'd0},  // second dot: decimal, then the dot
    '{8'h22, 1'b0, TK_INT,     16'd0, 16'd0},
    '{"x",   1'b0, TK_INT,     16'd0, 16'd0},
    '{8'h00, 1'b0, TK_INT,     16'd0, 16'd0},  // string still open at end
    '{"7",   1'b0, TK_INT,     16'd0, 16'd0},
    '{".",   1'b0, TK_INT,     16'd0, 16'd0},
    '{")",   1'b0, TK_INT,     16'd0, 16'd0},  // trailing dot stays in the decimal
    '{"i",   1'b0, TK_INT,     16'd0, 16'd0},
    '{"f",   1'b0, TK_INT,     16'd0, 16'd0},
    '{" ",   1'b1, TK_KW_IF,   16'd3, 16'd2},
    '{8'h22, 1'b0, TK_INT,     16'd0, 16'd0},
    '{8'h22, 1'b1, TK_STRING,  16'd7, 16'd0},  // empty string
    '{8'h80, 1'b0, TK_INT,     16'd0, 16'd0},  // top bit set: dropped
    '{8'h00, 1'b1, TK_END,     16'd9, 16'd0}
  };

  string kw_words   [0:5] = '{"int", "decimal", "string", "if", "else", "include"};
  string near_words [0:5] = '{"in", "inc", "includes", "els", "strings", "iff"};
  string op_words   [0:15] = '{"=", "==", "!", "!=", "+", "-", "*", "/",
                               ".", ",", ":", ";", "(", ")", "{", "}"};

  // Predictor state.
  scan_e       lx_mode;
  logic [15:0] lx_pos;
  logic [15:0] lx_start;
  logic [7:0]  lx_pre [0:KeywordBytes-1];
  logic        lx_dot;
  tok_t        lex_out [$];

  tok_t  tokens_due [$];  // tokens still owed by the block, oldest first
  note_t byte_notes [$];  // one per byte presented, popped when the byte is taken
  int    err_count;
  int    tok_count;
  int    rand_sent;
  bit    gaps_on;

  function automatic logic is_alpha_c(logic [7:0] c);
    return (c == "_") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_num_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank_c(logic [7:0] c);
    return (c >= 8'd8 && c <= 8'd13) || c == " ";
  endfunction

  function automatic void add_tok(tok_kind_e k, logic [15:0] s, logic [15:0] n);
    tok_t t;
    t.kind   = k;
    t.start  = s;
    t.length = n;
    t.last   = 1'b0;
    lex_out.push_back(t);
  endfunction

  function automatic logic [15:0] span_now();
    return (lx_pos >= lx_start) ? lx_pos - lx_start : 16'd0;
  endfunction

  function automatic void bump_pos();
    if (lx_pos != PosMax) lx_pos++;
  endfunction

  // Keyword lookup: bytes past the word are zero, so compare the whole prefix.
  function automatic tok_kind_e word_kind(logic [15:0] len);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < KeywordBytes; i++) w = {w[55:0], lx_pre[i]};
    if (len == 16'd3 && w == {"int", 40'd0})     return TK_KW_INT;
    if (len == 16'd7 && w == {"decimal", 8'd0})  return TK_KW_DECIMAL;
    if (len == 16'd6 && w == {"string", 16'd0})  return TK_KW_STRING;
    if (len == 16'd2 && w == {"if", 48'd0})      return TK_KW_IF;
    if (len == 16'd4 && w == {"else", 32'd0})    return TK_KW_ELSE;
    if (len == 16'd7 && w == {"include", 8'd0})  return TK_KW_INCLUDE;
    return TK_IDENT;
  endfunction

  // Advance the predictor by one source byte; the tokens it causes land in lex_out.
  function automatic void lex_byte(logic [7:0] c);
    logic        fresh;
    logic [15:0] len;
    fresh = 1'b1;
    case (lx_mode)
      SC_STRING: begin
        fresh = 1'b0;
        if (c == 8'h22) begin
          add_tok(TK_STRING, lx_start, span_now());
          lx_mode = SC_IDLE;
          bump_pos();
        end else if (c == 8'h00) begin
          add_tok(TK_OPEN_STR, lx_start, span_now());
          add_tok(TK_END, lx_pos, 16'd0);
          lx_mode = SC_IDLE;
          lx_pos  = '0;
        end else begin
          bump_pos();
        end
      end
      SC_EQ, SC_BANG: begin
        if (c == "=") begin
          if (lx_mode == SC_EQ) add_tok(TK_EQ, lx_start, 16'd2);
          else add_tok(TK_NE, lx_start, 16'd2);
          bump_pos();
          fresh = 1'b0;
        end else begin
          if (lx_mode == SC_EQ) add_tok(TK_ASSIGN, lx_start, 16'd1);
          else add_tok(TK_BANG, lx_start, 16'd1);
        end
        lx_mode = SC_IDLE;
      end
      SC_IDENT: begin
        len = span_now();
        if (is_alpha_c(c)) begin
          if (len < KeywordBytes) lx_pre[len[KwIdxBits-1:0]] = c;
          bump_pos();
          fresh = 1'b0;
        end else begin
          add_tok(word_kind(len), lx_start, len);
          lx_mode = SC_IDLE;
        end
      end
      SC_NUMBER: begin
        if (is_num_c(c)) begin
          bump_pos();
          fresh = 1'b0;
        end else if (c == "." && !lx_dot) begin
          lx_dot = 1'b1;
          bump_pos();
          fresh = 1'b0;
        end else begin
          if (lx_dot) add_tok(TK_DECIMAL, lx_start, span_now());
          else add_tok(TK_INT, lx_start, span_now());
          lx_mode = SC_IDLE;
        end
      end
      default: lx_mode = SC_IDLE;
    endcase

    // Handle the byte afresh when no pending token swallowed it.
    if (fresh) begin
      if (c == 8'h00) begin
        add_tok(TK_END, lx_pos, 16'd0);
        lx_mode = SC_IDLE;
        lx_pos  = '0;
      end else begin
        if (is_num_c(c)) begin
          lx_mode  = SC_NUMBER;
          lx_start = lx_pos;
          lx_dot   = 1'b0;
        end else if (is_alpha_c(c)) begin
          lx_mode  = SC_IDENT;
          lx_start = lx_pos;
          for (int i = 0; i < KeywordBytes; i++) lx_pre[i] = '0;
          lx_pre[0] = c;
        end else if (c == 8'h22) begin
          lx_mode  = SC_STRING;
          lx_start = (lx_pos != PosMax) ? lx_pos + 16'd1 : PosMax;
        end else if (c == "=") begin
          lx_mode  = SC_EQ;
          lx_start = lx_pos;
        end else if (c == "!") begin
          lx_mode  = SC_BANG;
          lx_start = lx_pos;
        end else if (!is_blank_c(c)) begin
          case (c)
            "+":     add_tok(TK_PLUS, lx_pos, 16'd1);
            "-":     add_tok(TK_MINUS, lx_pos, 16'd1);
            "*":     add_tok(TK_STAR, lx_pos, 16'd1);
            "/":     add_tok(TK_SLASH, lx_pos, 16'd1);
            ".":     add_tok(TK_DOT, lx_pos, 16'd1);
            ",":     add_tok(TK_COMMA, lx_pos, 16'd1);
            ":":     add_tok(TK_COLON, lx_pos, 16'd1);
            ";":     add_tok(TK_SEMI, lx_pos, 16'd1);
            "(":     add_tok(TK_LPAREN, lx_pos, 16'd1);
            ")":     add_tok(TK_RPAREN, lx_pos, 16'd1);
            "{":     add_tok(TK_LBRACE, lx_pos, 16'd1);
            "}":     add_tok(TK_RBRACE, lx_pos, 16'd1);
            default: ;  // unknown byte: drop it, the position still moves
          endcase
        end
        bump_pos();
      end
    end

    if (lex_out.size() != 0) lex_out[lex_out.size() - 1].last = 1'b1;
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Present one byte at the falling edge and hold it until the block takes it.
  task automatic drive_byte(logic [7:0] c, note_t nt);
    int gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      chr_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    chr_if.char_code = c;
    chr_if.valid     = 1'b1;
    byte_notes.push_back(nt);
    do @(posedge clk_i); while (!chr_if.ready);
    @(negedge clk_i);
  endtask

  task automatic put_byte(logic [7:0] c);
    note_t nt;
    nt.typed = 1'b0;
    nt.tok   = '0;
    rand_sent++;
    drive_byte(c, nt);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return Letters[$urandom_range(0, Letters.len() - 1)];
  endfunction

  // One lexeme of random content; neighbors run together unless whitespace is drawn,
  // so plenty of bytes break off the token before them.
  task automatic put_lexeme();
    int          pick;
    int          n;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      put_text(kw_words[$urandom_range(0, 5)]);
    end else if (pick < 20) begin
      put_text(near_words[$urandom_range(0, 5)]);
    end else if (pick < 30) begin
      n = $urandom_range(1, 10);
      repeat (n) put_byte(rand_letter());
    end else if (pick < 42) begin
      n = $urandom_range(1, 5);
      repeat (n) put_byte("0" + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 2) == 0) begin
        put_byte(".");
        n = $urandom_range(0, 3);
        repeat (n) put_byte("0" + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 4) == 0) put_byte(".");
      end
    end else if (pick < 54) begin
      // Quoted string with arbitrary content; now and then leave it open and end
      // the source inside it.
      put_byte(8'h22);
      n = $urandom_range(0, 6);
      repeat (n) begin
        do c = 8'($urandom_range(1, 255)); while (c == 8'h22);
        put_byte(c);
      end
      if ($urandom_range(0, 7) == 0) put_byte(8'h00);
      else put_byte(8'h22);
    end else if (pick < 74) begin
      put_text(op_words[$urandom_range(0, 15)]);
    end else if (pick < 88) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        c = 8'($urandom_range(7, 13));
        put_byte((c == 8'd7) ? 8'h20 : c);
      end
    end else begin
      put_byte(8'($urandom_range(1, 255)));
    end
  endtask

  // Token side: stall for a drawn number of cycles before each token, then take it.
  initial begin
    int w;
    tok_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = gaps_on ? $urandom_range(0, 6) : 0;
      if (w != 0) begin
        tok_if.ready = 1'b0;
        repeat (w) @(negedge clk_i);
      end
      tok_if.ready = 1'b1;
      do @(posedge clk_i); while (!tok_if.valid);
    end
  end

  // Scoreboard. Take bytes first, then tokens; the token queue is registered,
  // so a token never leaves in the same cycle as its byte.
  always @(posedge clk_i) begin
    note_t nt;
    tok_t  got;
    tok_t  want;
    if (rst_ni) begin
      if (chr_if.valid && chr_if.ready) begin
        lex_out.delete();
        lex_byte(chr_if.char_code);
        nt = byte_notes.pop_front();
        if (nt.typed) tokens_due.push_back(nt.tok);
        else foreach (lex_out[i]) tokens_due.push_back(lex_out[i]);
      end
      if (tok_if.valid && tok_if.ready) begin
        got.kind   = tok_if.token_kind;
        got.start  = tok_if.token_start;
        got.length = tok_if.token_length;
        got.last   = tok_if.last_of_run;
        if (tokens_due.size() == 0) begin
          flag_error($sformatf("token %0d unexpected: kind %0d start %0d len %0d last %0b",
                               tok_count, got.kind, got.start, got.length, got.last));
        end else begin
          want = tokens_due.pop_front();
          if (got !== want) begin
            flag_error($sformatf(
                "token %0d: want kind %0d start %0d len %0d last %0b, got %0d %0d %0d %0b",
                tok_count, want.kind, want.start, want.length, want.last,
                got.kind, got.start, got.length, got.last));
          end
        end
        tok_count++;
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb_source_text_tokenizer_core: done, errors");
    $finish;
  end

  initial begin
    note_t nt;
    int    spins;
    int    n;
    chr_if.valid     = 1'b0;
    chr_if.char_code = 8'h00;
    err_count        = 0;
    tok_count        = 0;
    rand_sent        = 0;
    gaps_on          = 1'b1;
    lx_mode          = SC_IDLE;
    lx_pos           = '0;
    lx_start         = '0;
    lx_dot           = 1'b0;
    for (int i = 0; i < KeywordBytes; i++) lx_pre[i] = '0;

    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows.
    foreach (plan[i]) begin
      nt.typed      = plan[i].typed;
      nt.tok.kind   = plan[i].kind;
      nt.tok.start  = plan[i].start;
      nt.tok.length = plan[i].len;
      nt.tok.last   = 1'b1;
      drive_byte(plan[i].c, nt);
    end

    // Random sources, each closed by a zero byte; some run with stalls, some without.
    rand_sent = 0;
    while (rand_sent < RandomItems) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(3, 20);
      repeat (n) put_lexeme();
      put_byte(8'h00);
    end
    chr_if.valid = 1'b0;
    gaps_on      = 1'b1;

    // Drain, then give a late stray token time to show up.
    spins = 0;
    while (tokens_due.size() != 0 && spins < 5000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (20) @(posedge clk_i);
    if (tokens_due.size() != 0) begin
      flag_error($sformatf("%0d tokens never arrived", tokens_due.size()));
    end

    if (err_count == 0) begin
      $display("tb_source_text_tokenizer_core: done, clean");
    end else begin
      $display("tb_source_text_tokenizer_core: done, errors");
    end
    $finish;
  end

endmodule
